// ===== rtl/sliding_window_percentile_monitor_defines.svh =====
// assertion macros shared by the monitor rtl
`ifndef SLIDING_WINDOW_PERCENTILE_MONITOR_DEFINES_SVH
`define SLIDING_WINDOW_PERCENTILE_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds on every cycle out of reset
`define SWPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("swpm check failed");

// same cycle implication
`define SWPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swpm check failed");

// next cycle implication
`define SWPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swpm check failed");

`else

`define SWPM_ASSERT(lbl, prop)
`define SWPM_ASSERT_IMP(lbl, ante, cons)
`define SWPM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/swpm_pkg.sv =====
// shared types and constants of the percentile monitor
`timescale 1ns / 1ps

package swpm_pkg;

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int TIME_W     = 40;
  localparam int SEQ_W      = 32;
  localparam int BAND_W     = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // default window depth
  localparam int WINDOW_DEFAULT = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TAIL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PCT = 2'd3;

  // register reset values
  localparam logic [SAMPLE_W-1:0] REF_TAIL_RST = 24'd0;
  localparam logic [BAND_W-1:0]   BAND_RST     = 16'd3277;
  localparam logic [SAMPLE_W-1:0] GAP_RST      = 24'd50000;
  localparam logic [PCT_W-1:0]    TAIL_PCT_RST = 7'd95;

  // one in q16
  localparam logic [BAND_W:0] Q16_ONE = 17'h10000;

  // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] K_RECIP = 13'd5243;
  localparam int          K_SHIFT = 19;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_us;
    logic [TIME_W-1:0]   now_us;
  } in_item_t;

  typedef struct packed {
    logic                stats_valid;
    logic [SAMPLE_W-1:0] median_us;
    logic [SAMPLE_W-1:0] tail_us;
    logic [SAMPLE_W-1:0] mean_us;
    logic                alarm;
    logic [SEQ_W-1:0]    alarm_seq;
  } out_item_t;

  // request to the sorted copy engine
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] new_us;
    logic [SAMPLE_W-1:0] old_us;
  } sort_req_t;

  // status of the sorted copy engine
  typedef struct packed {
    logic                busy;
    logic [SAMPLE_W-1:0] median_us;
    logic [SAMPLE_W-1:0] tail_us;
  } sort_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RING,
    ST_WAIT,
    ST_EVAL
  } swpm_state_e;

  typedef enum logic [2:0] {
    SS_IDLE,
    SS_PASS,
    SS_RD_MED,
    SS_RD_TAIL,
    SS_LAST
  } sort_state_e;

endpackage

// ===== rtl/swpm_div.sv =====
// mean of the window: window sum times a reciprocal of the window depth
`timescale 1ns / 1ps

module swpm_div #(
  parameter int WINDOW = swpm_pkg::WINDOW_DEFAULT,
  parameter int SUM_W  = swpm_pkg::SAMPLE_W + $clog2(swpm_pkg::WINDOW_DEFAULT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SUM_W-1:0]              dividend_i,
  output logic                          busy_o,
  output logic [swpm_pkg::SAMPLE_W-1:0] quot_o
);
  import swpm_pkg::*;

  // floor(x / WINDOW) as (x * RECIP) >> SH, exact for every x below 2^SUM_W
  localparam int SH    = SUM_W + $clog2(WINDOW);
  localparam int MW    = SUM_W + 2;
  localparam int DIG_W = 16;
  localparam int NDIG  = (MW + DIG_W - 1) / DIG_W;
  localparam int RW    = NDIG * DIG_W;
  localparam int PW    = SUM_W + RW;
  localparam int PP_W  = SUM_W + DIG_W;
  localparam int NW    = $clog2(NDIG + 1);
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(WINDOW - 1)) / 64'(WINDOW));

  logic [SUM_W-1:0] x_q;
  logic [RW-1:0]    m_q, m_d;
  logic [PW-1:0]    acc_q, acc_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [PP_W-1:0]  part;

  // one reciprocal digit per cycle, most significant first
  always_comb begin
    part  = PP_W'(x_q) * PP_W'(m_q[RW-1 -: DIG_W]);
    acc_d = {acc_q[PW-DIG_W-1:0], {DIG_W{1'b0}}} + PW'(part);
    m_d   = {m_q[RW-DIG_W-1:0], {DIG_W{1'b0}}};
    cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= NW'(NDIG);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  // product builds up as the digits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      m_q   <= RECIP;
      acc_q <= '0;
    end else if (busy_o) begin
      m_q   <= m_d;
      acc_q <= acc_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = acc_q[SH +: SAMPLE_W];

endmodule

// ===== rtl/swpm_sort.sv =====
// sorted copy of the window in a memory, updated by one pass per item
`timescale 1ns / 1ps

module swpm_sort #(
  parameter int WINDOW = swpm_pkg::WINDOW_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swpm_pkg::sort_req_t       req_i,
  input  logic [$clog2(WINDOW)-1:0] k_i,
  output swpm_pkg::sort_rsp_t       rsp_o
);
  import swpm_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 2);

  sort_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rdata_q;

  logic [CW-1:0]       cnt_q;
  logic [SAMPLE_W-1:0] a_q, p_q, n_q, o_q;
  logic                left_q, ins_q, rem_q, init_q;
  logic                ins_d, rem_d;
  logic [SAMPLE_W-1:0] med_q, tail_q;

  logic                rd_en, we, step, last;
  logic [AW-1:0]       raddr, waddr;
  logic [SAMPLE_W-1:0] b, t;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SS_IDLE:    if (req_i.start) state_d = SS_PASS;
      SS_PASS:    if (last) state_d = SS_RD_MED;
      SS_RD_MED:  state_d = SS_RD_TAIL;
      SS_RD_TAIL: state_d = SS_LAST;
      SS_LAST:    state_d = SS_IDLE;
      default:    state_d = SS_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    case (state_q)
      SS_PASS: begin
        rd_en = (cnt_q < CW'(WINDOW));
        raddr = AW'(cnt_q);
      end
      SS_RD_MED: begin
        rd_en = 1'b1;
        raddr = AW'(WINDOW / 2);
      end
      SS_RD_TAIL: begin
        rd_en = 1'b1;
        raddr = k_i;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // entries never written by a pass read as zero
  assign b     = init_q ? rdata_q : '0;
  assign last  = (state_q == SS_PASS) && (cnt_q == CW'(WINDOW + 1));
  assign step  = (state_q == SS_PASS) && (cnt_q >= CW'(2));
  assign we    = step;
  assign waddr = AW'(cnt_q - CW'(2));

  // one output entry per cycle from the window p, a, b of old entries
  always_comb begin
    t     = a_q;
    ins_d = ins_q;
    rem_d = rem_q;
    if (step) begin
      if (left_q) begin
        // new value not below old one: entries after the old one move down
        if (!rem_q) begin
          if (a_q == o_q) begin
            rem_d = 1'b1;
            if (!last && (b < n_q)) begin
              t = b;
            end else begin
              t     = n_q;
              ins_d = 1'b1;
            end
          end
        end else if (!ins_q) begin
          if (last || (b >= n_q)) begin
            t     = n_q;
            ins_d = 1'b1;
          end else begin
            t = b;
          end
        end
      end else begin
        // new value below old one: entries before the old one move up
        if (!ins_q) begin
          if (a_q > n_q) begin
            t     = n_q;
            ins_d = 1'b1;
            rem_d = (a_q == o_q);
          end
        end else if (!rem_q) begin
          t     = p_q;
          rem_d = (a_q == o_q);
        end
      end
    end
  end

  // sorted memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= t;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SS_IDLE;
      cnt_q   <= '0;
      ins_q   <= 1'b0;
      rem_q   <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_i.start) begin
        cnt_q <= '0;
        ins_q <= 1'b0;
        rem_q <= 1'b0;
      end else if (state_q == SS_PASS) begin
        cnt_q <= cnt_q + CW'(1);
        ins_q <= ins_d;
        rem_q <= rem_d;
      end
      if (last) begin
        init_q <= 1'b1;
      end
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q    <= req_i.new_us;
      o_q    <= req_i.old_us;
      left_q <= (req_i.new_us >= req_i.old_us);
    end
    if (state_q == SS_PASS) begin
      a_q <= b;
      p_q <= a_q;
    end
    if (state_q == SS_RD_TAIL) begin
      med_q <= rdata_q;
    end
    if (state_q == SS_LAST) begin
      tail_q <= rdata_q;
    end
  end

  assign rsp_o.busy      = (state_q != SS_IDLE);
  assign rsp_o.median_us = med_q;
  assign rsp_o.tail_us   = tail_q;

endmodule

// ===== rtl/sliding_window_percentile_monitor.sv =====
// top level of the sliding window percentile monitor
`timescale 1ns / 1ps
`include "sliding_window_percentile_monitor_defines.svh"

// Sliding window percentile monitor. Each item carries a duration sample and a
// timestamp; the block keeps the last WINDOW samples in a ring memory and a
// sorted copy of them in a second memory, and returns one result per item with
// median, tail percentile and truncated mean once the window has filled, plus a
// rate-limited alarm with a sequence number when the tail leaves the band
// around the reference. An item is not accepted until the previous one has
// left the evaluation: the ring read, a pass that rewrites the sorted copy
// one memory entry per cycle, the two rank reads, then the hand-off, the
// evaluation and the return to idle. The mean comes from a reciprocal
// multiplication, one digit at a time, that finishes well inside the pass.
// The evaluation waits while the output register holds a stalled result; once
// the result sits in the output register, the next item is taken while it
// waits. No clearing pass follows reset: unwritten ring slots read as zero
// until the window has filled. Registers are to be written by the user only
// while the block is idle; the block itself does not enforce this.
module sliding_window_percentile_monitor #(
  parameter int WINDOW = swpm_pkg::WINDOW_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swpm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swpm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  swpm_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output swpm_pkg::out_item_t                 out_item_o
);
  import swpm_pkg::*;

  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int KX_W  = $clog2(((1 << PCT_W) - 1) * WINDOW + 1);
  localparam int KM_W  = KX_W + 13;
  localparam int KQ_W  = KM_W - K_SHIFT;

  // configuration registers
  logic [SAMPLE_W-1:0] ref_tail_q;
  logic [BAND_W-1:0]   band_q;
  logic [SAMPLE_W-1:0] gap_q;
  logic [PCT_W-1:0]    tail_pct_q;

  swpm_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] sample_q;
  logic [TIME_W-1:0]   now_q;

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] ring_rdata_q;
  logic                ring_rd, ring_we;

  logic [AW-1:0]       slot_q, slot_d;
  logic                filled_q, filled_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [TIME_W-1:0]   last_alarm_q;
  logic [SEQ_W-1:0]    alarm_count_q;

  // derived from configuration and timestamps, refreshed every cycle
  logic [KM_W-1:0]     kmul_q;
  logic [KX_W-1:0]     kx;
  logic [KQ_W-1:0]     kq;
  logic [AW-1:0]       k_q;
  logic [BAND_W:0]     hi_f, lo_f;
  logic [TIME_W:0]     hi_q, lo_q;
  logic                gap_ok_q;

  logic                accept, commit, alarm_now, oob;
  logic [SAMPLE_W-1:0] old_us;
  logic [TIME_W:0]     t16;

  sort_req_t           sort_req;
  sort_rsp_t           sort_rsp;
  logic                div_start, div_busy;
  logic [SAMPLE_W-1:0] mean_us;

  out_item_t           result;
  logic                out_valid_q;
  out_item_t           out_item_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_tail_q <= REF_TAIL_RST;
      band_q     <= BAND_RST;
      gap_q      <= GAP_RST;
      tail_pct_q <= TAIL_PCT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REF_TAIL: ref_tail_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_BAND:     band_q     <= cfg_data_i[BAND_W-1:0];
        CFG_GAP:      gap_q      <= cfg_data_i[SAMPLE_W-1:0];
        CFG_TAIL_PCT: tail_pct_q <= cfg_data_i[PCT_W-1:0];
        default:      ref_tail_q <= ref_tail_q;
      endcase
    end
  end

  // tail rank, band limits and alarm gap check
  assign kx   = KX_W'(32'(tail_pct_q) * WINDOW);
  assign kq   = kmul_q[KM_W-1:K_SHIFT];
  assign hi_f = Q16_ONE + (BAND_W+1)'(band_q);
  assign lo_f = Q16_ONE - (BAND_W+1)'(band_q);

  always_ff @(posedge clk_i) begin
    kmul_q   <= KM_W'(kx) * KM_W'(K_RECIP);
    k_q      <= (32'(kq) > WINDOW - 1) ? AW'(WINDOW - 1) : AW'(kq);
    hi_q     <= (TIME_W+1)'(ref_tail_q) * (TIME_W+1)'(hi_f);
    lo_q     <= (TIME_W+1)'(ref_tail_q) * (TIME_W+1)'(lo_f);
    gap_ok_q <= (now_q >= last_alarm_q) &&
                ((now_q - last_alarm_q) >= TIME_W'(gap_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_RING;
      ST_RING: state_d = ST_WAIT;
      ST_WAIT: if (!sort_rsp.busy && !div_busy) state_d = ST_EVAL;
      ST_EVAL: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // datapath and control outputs
  always_comb begin
    ring_rd   = accept;
    ring_we   = (state_q == ST_RING);
    old_us    = filled_q ? ring_rdata_q : '0;
    sum_d     = sum_q - SUM_W'(old_us) + SUM_W'(sample_q);
    slot_d    = (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
    filled_d  = filled_q || (slot_q == AW'(WINDOW - 1));
    div_start = ring_we;

    sort_req.start  = ring_we;
    sort_req.new_us = sample_q;
    sort_req.old_us = old_us;

    t16       = (TIME_W+1)'({sort_rsp.tail_us, 16'h0000});
    oob       = (t16 > hi_q) || (t16 < lo_q);
    alarm_now = filled_q && oob && gap_ok_q;
    commit    = (state_q == ST_EVAL) && (!out_valid_q || !out_stall_i);

    result.stats_valid = filled_q;
    result.median_us   = filled_q ? sort_rsp.median_us : '0;
    result.tail_us     = filled_q ? sort_rsp.tail_us : '0;
    result.mean_us     = filled_q ? mean_us : '0;
    result.alarm       = alarm_now;
    result.alarm_seq   = alarm_now ? alarm_count_q : '0;
  end

  // sample ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= sample_q;
    end
    if (ring_rd) begin
      ring_rdata_q <= ring_mem[slot_q];
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_item_i.sample_us;
      now_q    <= in_item_i.now_us;
    end
    if (commit) begin
      out_item_q <= result;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slot_q        <= '0;
      filled_q      <= 1'b0;
      sum_q         <= '0;
      last_alarm_q  <= '0;
      alarm_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ring_we) begin
        slot_q   <= slot_d;
        filled_q <= filled_d;
        sum_q    <= sum_d;
      end
      if (commit && alarm_now) begin
        last_alarm_q  <= now_q;
        alarm_count_q <= alarm_count_q + SEQ_W'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // sorted copy and rank reads
  swpm_sort #(
    .WINDOW (WINDOW)
  ) u_sort (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sort_req),
    .k_i    (k_q),
    .rsp_o  (sort_rsp)
  );

  // mean of the window
  swpm_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .busy_o     (div_busy),
    .quot_o     (mean_us)
  );

  // checks
  `SWPM_ASSERT(slot_in_range, 32'(slot_q) < WINDOW)
  `SWPM_ASSERT_IMP(sort_start_idle, sort_req.start, !sort_rsp.busy && !div_busy)
  `SWPM_ASSERT_IMP(alarm_needs_stats, out_valid_o && out_item_o.alarm, out_item_o.stats_valid)
  `SWPM_ASSERT_NXT(alarm_count_step, commit && alarm_now, alarm_count_q == $past(alarm_count_q) + 32'd1)

endmodule

// ===== tb/swpm_checker.sv =====
// checker of the percentile monitor: watches both channels, predicts and compares
`timescale 1ns / 1ps

module swpm_checker #(
  parameter int WIN = swpm_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swpm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  swpm_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  swpm_pkg::out_item_t             out_item_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     n_pending_o,
  output int unsigned                     n_checked_o,
  output int unsigned                     n_alarms_o
);
  import swpm_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WIN);

  // register copies
  logic [SAMPLE_W-1:0] ref_tail_r;
  logic [BAND_W-1:0]   band_r;
  logic [SAMPLE_W-1:0] gap_r;
  logic [PCT_W-1:0]    pct_r;

  // window and alarm state
  logic [SAMPLE_W-1:0] ring_q [WIN];
  logic [SUM_W-1:0]    win_sum;
  int unsigned         slot;
  bit                  filled;
  logic [TIME_W-1:0]   last_alarm;
  logic [SEQ_W-1:0]    alarm_cnt;

  out_item_t   stats_due_q [$];
  int unsigned n_fail, n_checked, n_alarms;

  task automatic clear_window();
    ref_tail_r = REF_TAIL_RST;
    band_r     = BAND_RST;
    gap_r      = GAP_RST;
    pct_r      = TAIL_PCT_RST;
    for (int i = 0; i < WIN; i++) ring_q[i] = '0;
    win_sum    = '0;
    slot       = 0;
    filled     = 1'b0;
    last_alarm = '0;
    alarm_cnt  = '0;
    stats_due_q.delete();
  endtask

  // advance the window by one sample and work out the statistics it yields
  task automatic window_stats(input in_item_t it, output out_item_t res);
    logic [SAMPLE_W-1:0] ordered [WIN];
    logic [SAMPLE_W-1:0] key;
    int                  j;
    int unsigned         k;
    logic [63:0]         t16, hi, lo;
    bit                  out_band, gap_ok;
    res = '0;
    win_sum = win_sum - SUM_W'(ring_q[slot]) + SUM_W'(it.sample_us);
    ring_q[slot] = it.sample_us;
    slot++;
    if (slot == WIN) begin
      slot = 0;
      filled = 1'b1;
    end
    if (!filled) return;

    // insertion sort of the ring
    for (int i = 0; i < WIN; i++) begin
      key = ring_q[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = key;
    end

    // tail rank saturates at the top of the window
    k = (int'(pct_r) * WIN) / 100;
    if (k > WIN - 1) k = WIN - 1;
    res.stats_valid = 1'b1;
    res.median_us   = ordered[WIN/2];
    res.tail_us     = ordered[k];
    res.mean_us     = SAMPLE_W'(win_sum / WIN);

    // exact band test in q16
    t16 = 64'(res.tail_us) << 16;
    hi  = 64'(ref_tail_r) * (64'd65536 + 64'(band_r));
    lo  = 64'(ref_tail_r) * (64'd65536 - 64'(band_r));
    out_band = (t16 > hi) || (t16 < lo);
    // a timestamp behind the last alarm never counts as elapsed
    gap_ok = (it.now_us >= last_alarm) && (64'(it.now_us - last_alarm) >= 64'(gap_r));
    if (out_band && gap_ok) begin
      res.alarm     = 1'b1;
      res.alarm_seq = alarm_cnt;
      alarm_cnt++;
      last_alarm = it.now_us;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("field %s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // channel watch
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t fresh, want;
    if (!rst_ni) begin
      clear_window();
      n_fail    = 0;
      n_checked = 0;
      n_alarms  = 0;
      fail_count_o <= 0;
      n_pending_o  <= 0;
      n_checked_o  <= 0;
      n_alarms_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_TAIL: ref_tail_r = cfg_data_i[SAMPLE_W-1:0];
          CFG_BAND:     band_r     = cfg_data_i[BAND_W-1:0];
          CFG_GAP:      gap_r      = cfg_data_i[SAMPLE_W-1:0];
          CFG_TAIL_PCT: pct_r      = cfg_data_i[PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        window_stats(in_item_i, fresh);
        stats_due_q.insert(stats_due_q.size(), fresh);
      end
      if (out_valid_i && !out_stall_i) begin
        if (stats_due_q.size() == 0) begin
          $error("result item with no expectation pending");
          n_fail++;
        end else begin
          want = stats_due_q[0];
          stats_due_q.delete(0);
          check_field("stats_valid", want.stats_valid, out_item_i.stats_valid);
          check_field("median_us", want.median_us, out_item_i.median_us);
          check_field("tail_us", want.tail_us, out_item_i.tail_us);
          check_field("mean_us", want.mean_us, out_item_i.mean_us);
          check_field("alarm", want.alarm, out_item_i.alarm);
          check_field("alarm_seq", want.alarm_seq, out_item_i.alarm_seq);
          n_checked++;
          if (want.alarm) n_alarms++;
        end
      end
      fail_count_o <= n_fail;
      n_pending_o  <= stats_due_q.size();
      n_checked_o  <= n_checked;
      n_alarms_o   <= n_alarms;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// top of the percentile monitor testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import swpm_pkg::*;

  localparam int          WIN         = WINDOW_DEFAULT;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_item   = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_item;

  int unsigned fail_count, n_pending, n_checked, n_alarms;
  int unsigned n_sent     = 0;
  int unsigned n_recv     = 0;
  int unsigned n_settings = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  logic [TIME_W-1:0] clock_us = '0;

  sliding_window_percentile_monitor #(
    .WINDOW(WIN)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  swpm_checker #(
    .WIN(WIN)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .n_pending_o  (n_pending),
    .n_checked_o  (n_checked),
    .n_alarms_o   (n_alarms)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, one long hold-off, one quiet stretch
  always @(posedge clk) begin
    if (out_valid && !out_stall) n_recv++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_recv >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (n_recv >= 600 && n_recv < 800) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 14);
    end
  end

  // sample around a base, with outliers, full range values and the extremes
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned base,
                                                      input int unsigned spread);
    int unsigned r;
    longint      v;
    r = $urandom_range(0, 99);
    if (r < 60)      v = longint'(base) + $urandom_range(0, spread);
    else if (r < 72) v = longint'(base) + spread + $urandom_range(0, 2 * spread);
    else if (r < 82) v = $urandom_range(0, base);
    else if (r < 92) v = $urandom & SAMPLE_MAX;
    else if (r < 96) v = 0;
    else             v = SAMPLE_MAX;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  // timestamps mostly move forward, sometimes step back or jump anywhere
  function automatic logic [TIME_W-1:0] next_now(input int unsigned inc_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)      clock_us = TIME_W'({$urandom, $urandom});
    else if (r < 8) clock_us = clock_us - $urandom_range(0, inc_max);
    else            clock_us = clock_us + $urandom_range(0, inc_max);
    return clock_us;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    if (!(n_sent >= 600 && n_sent < 800) && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sample_us: s, now_us: t};
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic program_regs(input logic [SAMPLE_W-1:0] ref_tail,
                              input logic [BAND_W-1:0] band,
                              input logic [SAMPLE_W-1:0] gap,
                              input logic [PCT_W-1:0] pct);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idxs [4];
    vals = '{ref_tail, CFG_DATA_W'(band), gap, CFG_DATA_W'(pct)};
    idxs = '{CFG_REF_TAIL, CFG_BAND, CFG_GAP, CFG_TAIL_PCT};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // one register setting, then a stream whose level steps halfway through
  task automatic run_phase(input logic [SAMPLE_W-1:0] ref_tail,
                           input logic [BAND_W-1:0] band,
                           input logic [SAMPLE_W-1:0] gap,
                           input logic [PCT_W-1:0] pct,
                           input int unsigned n, input int unsigned base,
                           input int unsigned spread, input int unsigned shift);
    int unsigned inc_max;
    program_regs(ref_tail, band, gap, pct);
    inc_max = gap / 8 + 1;
    for (int unsigned i = 0; i < n; i++) begin
      send_item(pick_sample((i < n / 2) ? base : base + shift, spread), next_now(inc_max));
    end
    drain();
  endtask

  // stimulus
  initial begin : stimulus
    logic [SAMPLE_W-1:0] dir_sample [20];
    logic [TIME_W-1:0]   dir_now [20];
    int unsigned         base, spread, pct;
    longint              rt;
    dir_sample = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'hAAAAAA,
                   24'h555555, 24'h7FFFFF, 24'hFFFFFE, 24'h000000, 24'hFFFFFF,
                   24'h00FF00, 24'hFF00FF, 24'h0F0F0F, 24'hF0F0F0, 24'h000002,
                   24'h400000, 24'h123456, 24'hEDCBA9, 24'h000000, 24'hFFFFFF};
    dir_now = '{40'h0, 40'hFF_FFFF_FFFF, 40'h1, 40'h80_0000_0000, 40'hAA_AAAA_AAAA,
                40'h55_5555_5555, 40'h7F_FFFF_FFFF, 40'hFF_FFFF_FFFE, 40'h0, 40'h0,
                40'h00_0000_C350, 40'h00_0000_C34F, 40'h0F_0F0F_0F0F,
                40'hF0_F0F0_F0F0, 40'h2, 40'h40_0000_0000, 40'h12_3456_789A,
                40'hED_CBA9_8765, 40'hFF_FFFF_FFFF, 40'h0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes at reset settings, window still filling
    for (int i = 0; i < 20; i++) send_item(dir_sample[i], dir_now[i]);
    drain();
    clock_us = '0;

    // low extremes: zero reference, band and gap, rank zero
    run_phase('0, '0, '0, '0, 150, 1000, 500, 400);
    // high extremes: widest band, longest gap, top legal rank
    run_phase(SAMPLE_MAX, 16'hFFFF, SAMPLE_MAX, 7'd99, 150, 8_000_000, 8_000_000, 0);
    // rank beyond the window saturates
    run_phase(24'd30000, 16'd3277, 24'd5000, 7'd127, 120, 20000, 20000, 15000);
    run_phase(24'd500000, 16'd0, 24'd1000, 7'd100, 120, 400000, 100000, 50000);

    // random settings around the stream level
    for (int p = 0; p < 6; p++) begin
      base   = $urandom_range(0, 2_000_000);
      spread = $urandom_range(1, 100_000);
      pct    = $urandom_range(0, 99);
      rt     = longint'(base) + longint'(spread) * pct / 100;
      if (rt > SAMPLE_MAX) rt = SAMPLE_MAX;
      run_phase(SAMPLE_W'(rt),
                BAND_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 8000)
                                                   : $urandom_range(0, 65535)),
                SAMPLE_W'($urandom_range(0, 100_000)), PCT_W'(pct),
                120, base, spread, $urandom_range(0, spread));
    end

    repeat (2 * WIN) @(posedge clk);
    $display("covered %0d items over %0d register settings, including window fill,",
             n_sent, n_settings);
    $display("rank saturation and timestamp steps; %0d results checked, %0d alarms",
             n_checked, n_alarms);
    if (fail_count == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
